[sv/cartesian_to_frenet_assert.svh]
// assertion macros for the path conversion block
`ifndef CARTESIAN_TO_FRENET_ASSERT_SVH
`define CARTESIAN_TO_FRENET_ASSERT_SVH

// same-cycle implication
`define C2F_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C2F_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[sv/c2f_pkg.sv]
// ----------------------------------------------------------------------------
// c2f_pkg
// constants, codes and tables for the cartesian to frenet converter
// ----------------------------------------------------------------------------
package c2f_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;

    localparam int COORD_W = 32;
    localparam int ANG_W   = 16;
    localparam int DIFF_W  = 33;
    localparam int MAG_W   = 64;
    localparam int ACC_W   = 68;
    localparam int CORD_W  = 36;
    localparam int CORD_N  = 14;
    localparam int ROOT_W  = 49;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int SQREM_W = ROOT_W + 3;
    localparam int NUM_W   = 82;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int QUO_W   = 32;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ZERO_SEG = 2'd2;

    localparam logic [1:0] REG_CENTER_X      = 2'd0;
    localparam logic [1:0] REG_CENTER_Y      = 2'd1;
    localparam logic [1:0] REG_HEADING_LIMIT = 2'd2;

    localparam logic [31:0] CENTER_X_RST      = 32'd256000;
    localparam logic [31:0] CENTER_Y_RST      = 32'd512000;
    localparam logic [15:0] HEADING_LIMIT_RST = 16'd6434;

    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

    function automatic logic signed [15:0] atan_lut(input logic [3:0] k);
        logic signed [15:0] v;
        unique case (k)
            4'd0:    v = 16'sd6434;
            4'd1:    v = 16'sd3798;
            4'd2:    v = 16'sd2007;
            4'd3:    v = 16'sd1019;
            4'd4:    v = 16'sd511;
            4'd5:    v = 16'sd256;
            4'd6:    v = 16'sd128;
            4'd7:    v = 16'sd64;
            4'd8:    v = 16'sd32;
            4'd9:    v = 16'sd16;
            4'd10:   v = 16'sd8;
            4'd11:   v = 16'sd4;
            4'd12:   v = 16'sd2;
            4'd13:   v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DIFF_W-1:0] sub33(input logic [31:0] a,
                                                       input logic [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

endpackage

[sv/cartesian_to_frenet.sv]
// ----------------------------------------------------------------------------
// cartesian_to_frenet
// converts a query point to path distance and lateral offset against a
// table of waypoints loaded one word at a time
// ----------------------------------------------------------------------------
// The block takes one word at a time and is not ready until it has finished
// it. A clear and the first append are done in the idle state; a later
// append reads the last waypoint and runs the square root unit (49 steps)
// for the segment length. A query scans the stored waypoints for the
// nearest point through the address, wait, square and compare states, the
// single read port of the waypoint memory and the shared 32x32 multiplier,
// then takes 14 CORDIC steps for the bearing, 49 square root steps for the
// segment length and two 82-step long divisions for the projection and the
// offset. A query on an empty table goes straight to the output register.
// A result waits there until taken; the next word is accepted meanwhile.

`include "cartesian_to_frenet_assert.svh"

module cartesian_to_frenet #(
    parameter int MAX_WAYPOINTS = c2f_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // wp_x, wp_y, query_x, query_y, query_heading
    input  logic [143:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // s_dist, d_offset, next_index
    output logic [71:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W   = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_WAYPOINTS + 1);
    localparam int DIFF_W  = c2f_pkg::DIFF_W;
    localparam int MAG_W   = c2f_pkg::MAG_W;
    localparam int ACC_W   = c2f_pkg::ACC_W;
    localparam int CORD_W  = c2f_pkg::CORD_W;
    localparam int ROOT_W  = c2f_pkg::ROOT_W;
    localparam int RAD_W   = c2f_pkg::RAD_W;
    localparam int SQREM_W = c2f_pkg::SQREM_W;
    localparam int NUM_W   = c2f_pkg::NUM_W;
    localparam int DREM_W  = c2f_pkg::DREM_W;
    localparam int QUO_W   = c2f_pkg::QUO_W;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SRCH_ADDR = 5'd1;
    localparam logic [4:0] S_SRCH_WAIT = 5'd2;
    localparam logic [4:0] S_SRCH_SQX  = 5'd3;
    localparam logic [4:0] S_SRCH_SQY  = 5'd4;
    localparam logic [4:0] S_SRCH_CMP  = 5'd5;
    localparam logic [4:0] S_AT_INIT   = 5'd6;
    localparam logic [4:0] S_AT_STEP   = 5'd7;
    localparam logic [4:0] S_HEAD      = 5'd8;
    localparam logic [4:0] S_PRV_WAIT  = 5'd9;
    localparam logic [4:0] S_PRV_GET   = 5'd10;
    localparam logic [4:0] S_NXT_WAIT  = 5'd11;
    localparam logic [4:0] S_NXT_GET   = 5'd12;
    localparam logic [4:0] S_MP1       = 5'd13;
    localparam logic [4:0] S_MP2       = 5'd14;
    localparam logic [4:0] S_MP3       = 5'd15;
    localparam logic [4:0] S_MP_END    = 5'd16;
    localparam logic [4:0] S_SQRT      = 5'd17;
    localparam logic [4:0] S_DIV       = 5'd18;
    localparam logic [4:0] S_DIV_END   = 5'd19;
    localparam logic [4:0] S_APP_WAIT  = 5'd20;
    localparam logic [4:0] S_APP_GET   = 5'd21;
    localparam logic [4:0] S_APP_WR    = 5'd22;
    localparam logic [4:0] S_OUT       = 5'd23;

    localparam logic [2:0] J_NN   = 3'd0;
    localparam logic [2:0] J_DOT  = 3'd1;
    localparam logic [2:0] J_CRS  = 3'd2;
    localparam logic [2:0] J_SIDE = 3'd3;
    localparam logic [2:0] J_SEG  = 3'd4;

    logic [4:0]  state_reg;
    logic [2:0]  job_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] i_reg;
    logic [31:0] center_x_reg, center_y_reg;
    logic [15:0] heading_limit_reg;

    logic [31:0] wx_reg, wy_reg, qx_reg, qy_reg;
    logic [15:0] qh_reg;

    logic [31:0] wp_x_mem [MAX_WAYPOINTS];
    logic [31:0] wp_y_mem [MAX_WAYPOINTS];
    logic [31:0] cum_mem  [MAX_WAYPOINTS];
    logic [IDX_W-1:0] rd_addr_reg;
    logic [31:0] rdx_reg, rdy_reg, rdc_reg;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0] mem_wx, mem_wy, mem_wc;

    logic [IDX_W-1:0] best_reg, nxt_reg;
    logic [ACC_W-1:0] bestd_reg;
    logic signed [DIFF_W-1:0] bdx_reg, bdy_reg;
    logic signed [DIFF_W-1:0] nx_reg, ny_reg, xx_reg, xy_reg, ax_reg, ay_reg;
    logic [31:0] px_reg, py_reg, pcum_reg;

    logic signed [CORD_W-1:0] cd_x_reg, cd_y_reg;
    logic signed [15:0]       cd_z_reg;
    logic [3:0]               cd_k_reg;

    logic signed [DIFF_W-1:0] op_a, op_b;
    logic [DIFF_W-1:0] mag_a, mag_b;
    logic [MAG_W-1:0]  prod_mag_reg;
    logic              prod_neg_reg;
    logic signed [ACC_W-1:0] prod_s, acc_reg, c_reg, d_sum, w2, t_side;
    logic [ACC_W-1:0]  acc_abs, c_abs;
    logic [65:0]       dot_mag_reg;
    logic              d_neg_reg;

    logic [RAD_W-1:0]   sq_rad_reg;
    logic [SQREM_W-1:0] sq_rem_reg, sq_rem_sh, sq_trial;
    logic [ROOT_W-1:0]  sq_root_reg, len_reg;
    logic [5:0]         sq_cnt_reg;
    logic               sq_ge;

    logic [NUM_W-1:0]  dv_num_reg;
    logic [DREM_W-1:0] dv_rem_reg, dv_rem_sh, dv_den;
    logic [QUO_W-1:0]  dv_q_reg;
    logic              dv_ovf_reg, dv_sel_reg, dv_ge;
    logic [6:0]        dv_cnt_reg;

    logic [31:0] res_s_reg, res_d_reg;
    logic [7:0]  res_idx_reg;
    logic [1:0]  res_st_reg;
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic signed [16:0] hd_diff, hd_abs;
    logic               hd_gt;
    logic [CNT_W-1:0]   nxt_try, nxt_c, prv_c;
    logic signed [CORD_W-1:0] cd_xs, cd_ys;
    logic [QUO_W:0]     s_sum;
    logic [QUO_W-1:0]   pl_sat, dm_sat;
    logic [ROOT_W:0]    seg_sum;
    logic               s_acc;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        unique case (paddr[3:2])
            c2f_pkg::REG_CENTER_X:      prdata = center_x_reg;
            c2f_pkg::REG_CENTER_Y:      prdata = center_y_reg;
            c2f_pkg::REG_HEADING_LIMIT: prdata = {16'd0, heading_limit_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_SRCH_SQX: begin
                op_a = c2f_pkg::sub33(rdx_reg, qx_reg);
                op_b = op_a;
            end
            S_SRCH_SQY: begin
                op_a = c2f_pkg::sub33(rdy_reg, qy_reg);
                op_b = op_a;
            end
            S_MP1: begin
                unique case (job_reg)
                    J_NN:    begin op_a = nx_reg; op_b = nx_reg; end
                    J_DOT:   begin op_a = xx_reg; op_b = nx_reg; end
                    J_CRS:   begin op_a = nx_reg; op_b = xy_reg; end
                    J_SIDE:  begin
                        op_a = c2f_pkg::sub33(center_x_reg, qx_reg);
                        op_b = ny_reg;
                    end
                    default: begin op_a = ax_reg; op_b = ax_reg; end
                endcase
            end
            S_MP2: begin
                unique case (job_reg)
                    J_NN:    begin op_a = ny_reg; op_b = ny_reg; end
                    J_DOT:   begin op_a = xy_reg; op_b = ny_reg; end
                    J_CRS:   begin op_a = ny_reg; op_b = xx_reg; end
                    J_SIDE:  begin
                        op_a = c2f_pkg::sub33(center_y_reg, qy_reg);
                        op_b = nx_reg;
                    end
                    default: begin op_a = ay_reg; op_b = ay_reg; end
                endcase
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mag_a  = op_a[DIFF_W-1] ? $unsigned(-op_a) : $unsigned(op_a);
    assign mag_b  = op_b[DIFF_W-1] ? $unsigned(-op_b) : $unsigned(op_b);
    assign prod_s = prod_neg_reg ? -$signed({4'd0, prod_mag_reg})
                                 : $signed({4'd0, prod_mag_reg});
    assign d_sum  = acc_reg + prod_s;
    assign acc_abs = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign c_abs   = c_reg[ACC_W-1] ? $unsigned(-c_reg) : $unsigned(c_reg);
    assign w2      = acc_reg <<< 1;
    assign t_side  = $signed(c_abs) + (c_reg[ACC_W-1] ? -w2 : w2);

    // cordic and heading check
    assign cd_xs   = cd_x_reg >>> cd_k_reg;
    assign cd_ys   = cd_y_reg >>> cd_k_reg;
    assign hd_diff = $signed({qh_reg[15], qh_reg}) - $signed({cd_z_reg[15], cd_z_reg});
    assign hd_abs  = hd_diff[16] ? -hd_diff : hd_diff;
    assign hd_gt   = $unsigned(hd_abs) > {1'b0, heading_limit_reg};
    assign nxt_try = CNT_W'(best_reg) + CNT_W'(hd_gt);
    assign nxt_c   = (nxt_try >= cnt_reg) ? '0 : nxt_try;
    assign prv_c   = (nxt_c == '0) ? cnt_reg - 1'b1 : nxt_c - 1'b1;

    // square root and divider steps
    assign sq_rem_sh = {sq_rem_reg[SQREM_W-3:0], sq_rad_reg[RAD_W-1 -: 2]};
    assign sq_trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;
    assign dv_rem_sh = {dv_rem_reg[DREM_W-2:0], dv_num_reg[NUM_W-1]};
    assign dv_den    = {1'b0, len_reg};
    assign dv_ge     = dv_rem_sh >= dv_den;

    assign pl_sat  = (dv_ovf_reg) ? '1 : dv_q_reg;
    assign dm_sat  = (dv_ovf_reg || dv_q_reg[QUO_W-1]) ? 32'h7FFF_FFFF : dv_q_reg;
    assign s_sum   = {1'b0, pcum_reg} + {1'b0, pl_sat};
    assign seg_sum = {{(ROOT_W-31){1'b0}}, pcum_reg} + {1'b0, sq_root_reg};

    // waypoint memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[IDX_W-1:0];
        mem_wx    = wx_reg;
        mem_wy    = wy_reg;
        mem_wc    = (seg_sum[ROOT_W:32] != '0) ? 32'hFFFF_FFFF : seg_sum[31:0];
        if (state_reg == S_APP_WR) begin
            mem_we = 1'b1;
        end else if (s_acc && s_tuser == c2f_pkg::MODE_APPEND && cnt_reg == '0) begin
            mem_we = 1'b1;
            mem_wx = s_tdata[31:0];
            mem_wy = s_tdata[63:32];
            mem_wc = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wp_x_mem[mem_waddr] <= mem_wx;
            wp_y_mem[mem_waddr] <= mem_wy;
            cum_mem[mem_waddr]  <= mem_wc;
        end
        rdx_reg <= wp_x_mem[rd_addr_reg];
        rdy_reg <= wp_y_mem[rd_addr_reg];
        rdc_reg <= cum_mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        prod_mag_reg <= mag_a[31:0] * mag_b[31:0];
        prod_neg_reg <= op_a[DIFF_W-1] ^ op_b[DIFF_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
            center_x_reg      <= c2f_pkg::CENTER_X_RST;
            center_y_reg      <= c2f_pkg::CENTER_Y_RST;
            heading_limit_reg <= c2f_pkg::HEADING_LIMIT_RST;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    c2f_pkg::REG_CENTER_X:      center_x_reg <= pwdata;
                    c2f_pkg::REG_CENTER_Y:      center_y_reg <= pwdata;
                    c2f_pkg::REG_HEADING_LIMIT: heading_limit_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        wx_reg <= s_tdata[31:0];
                        wy_reg <= s_tdata[63:32];
                        qx_reg <= s_tdata[95:64];
                        qy_reg <= s_tdata[127:96];
                        qh_reg <= s_tdata[143:128];
                        i_reg  <= '0;
                        unique case (s_tuser)
                            c2f_pkg::MODE_APPEND: begin
                                if (cnt_reg == '0) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end else if (cnt_reg < CNT_W'(MAX_WAYPOINTS)) begin
                                    rd_addr_reg <= IDX_W'(cnt_reg - 1'b1);
                                    state_reg   <= S_APP_WAIT;
                                end
                            end
                            c2f_pkg::MODE_QUERY: begin
                                if (cnt_reg == '0) begin
                                    res_s_reg   <= '0;
                                    res_d_reg   <= '0;
                                    res_idx_reg <= '0;
                                    res_st_reg  <= c2f_pkg::ST_EMPTY;
                                    state_reg   <= S_OUT;
                                end else begin
                                    state_reg <= S_SRCH_ADDR;
                                end
                            end
                            c2f_pkg::MODE_CLEAR: cnt_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                S_SRCH_ADDR: begin
                    rd_addr_reg <= i_reg[IDX_W-1:0];
                    state_reg   <= S_SRCH_WAIT;
                end
                S_SRCH_WAIT: state_reg <= S_SRCH_SQX;
                S_SRCH_SQX:  state_reg <= S_SRCH_SQY;
                S_SRCH_SQY: begin
                    acc_reg   <= prod_s;
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (i_reg == '0 || $unsigned(d_sum) < bestd_reg) begin
                        bestd_reg <= $unsigned(d_sum);
                        best_reg  <= i_reg[IDX_W-1:0];
                        bdx_reg   <= c2f_pkg::sub33(rdx_reg, qx_reg);
                        bdy_reg   <= c2f_pkg::sub33(rdy_reg, qy_reg);
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg + 1'b1 == cnt_reg) begin
                        state_reg <= S_AT_INIT;
                    end else begin
                        state_reg <= S_SRCH_ADDR;
                    end
                end
                S_AT_INIT: begin
                    cd_k_reg <= '0;
                    if (bdx_reg == '0 && bdy_reg == '0) begin
                        cd_z_reg  <= '0;
                        state_reg <= S_HEAD;
                    end else begin
                        state_reg <= S_AT_STEP;
                        if (bdx_reg[DIFF_W-1] && !bdy_reg[DIFF_W-1]) begin
                            cd_x_reg <= CORD_W'(bdy_reg);
                            cd_y_reg <= -CORD_W'(bdx_reg);
                            cd_z_reg <= c2f_pkg::HALF_PI_Q13;
                        end else if (bdx_reg[DIFF_W-1]) begin
                            cd_x_reg <= -CORD_W'(bdy_reg);
                            cd_y_reg <= CORD_W'(bdx_reg);
                            cd_z_reg <= -c2f_pkg::HALF_PI_Q13;
                        end else begin
                            cd_x_reg <= CORD_W'(bdx_reg);
                            cd_y_reg <= CORD_W'(bdy_reg);
                            cd_z_reg <= '0;
                        end
                    end
                end
                S_AT_STEP: begin
                    if (cd_y_reg > 0) begin
                        cd_x_reg <= cd_x_reg + cd_ys;
                        cd_y_reg <= cd_y_reg - cd_xs;
                        cd_z_reg <= cd_z_reg + c2f_pkg::atan_lut(cd_k_reg);
                    end else if (cd_y_reg < 0) begin
                        cd_x_reg <= cd_x_reg - cd_ys;
                        cd_y_reg <= cd_y_reg + cd_xs;
                        cd_z_reg <= cd_z_reg - c2f_pkg::atan_lut(cd_k_reg);
                    end
                    cd_k_reg <= cd_k_reg + 1'b1;
                    if (cd_k_reg == 4'(c2f_pkg::CORD_N - 1)) begin
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    nxt_reg     <= nxt_c[IDX_W-1:0];
                    res_idx_reg <= 8'(nxt_c);
                    rd_addr_reg <= prv_c[IDX_W-1:0];
                    state_reg   <= S_PRV_WAIT;
                end
                S_PRV_WAIT: state_reg <= S_PRV_GET;
                S_PRV_GET: begin
                    px_reg      <= rdx_reg;
                    py_reg      <= rdy_reg;
                    pcum_reg    <= rdc_reg;
                    rd_addr_reg <= nxt_reg;
                    state_reg   <= S_NXT_WAIT;
                end
                S_NXT_WAIT: state_reg <= S_NXT_GET;
                S_NXT_GET: begin
                    nx_reg    <= c2f_pkg::sub33(rdx_reg, px_reg);
                    ny_reg    <= c2f_pkg::sub33(rdy_reg, py_reg);
                    xx_reg    <= c2f_pkg::sub33(qx_reg, px_reg);
                    xy_reg    <= c2f_pkg::sub33(qy_reg, py_reg);
                    job_reg   <= J_NN;
                    state_reg <= S_MP1;
                end
                S_MP1: state_reg <= S_MP2;
                S_MP2: begin
                    acc_reg   <= (job_reg == J_SIDE) ? -prod_s : prod_s;
                    state_reg <= S_MP3;
                end
                S_MP3: begin
                    acc_reg   <= (job_reg == J_CRS) ? acc_reg - prod_s : acc_reg + prod_s;
                    state_reg <= S_MP_END;
                end
                S_MP_END: begin
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_cnt_reg  <= '0;
                    unique case (job_reg)
                        J_SEG: begin
                            sq_rad_reg <= RAD_W'(acc_abs);
                            state_reg  <= S_SQRT;
                        end
                        J_NN: begin
                            if (acc_reg == '0) begin
                                res_s_reg  <= '0;
                                res_d_reg  <= '0;
                                res_st_reg <= c2f_pkg::ST_ZERO_SEG;
                                state_reg  <= S_OUT;
                            end else begin
                                sq_rad_reg <= {acc_abs[65:0], 32'd0};
                                job_reg    <= J_DOT;
                                state_reg  <= S_MP1;
                            end
                        end
                        J_DOT: begin
                            dot_mag_reg <= acc_abs[65:0];
                            job_reg     <= J_CRS;
                            state_reg   <= S_MP1;
                        end
                        J_CRS: begin
                            c_reg     <= acc_reg;
                            job_reg   <= J_SIDE;
                            state_reg <= S_MP1;
                        end
                        default: begin
                            d_neg_reg <= !t_side[ACC_W-1];
                            state_reg <= S_SQRT;
                        end
                    endcase
                end
                S_SQRT: begin
                    sq_rad_reg  <= sq_rad_reg << 2;
                    sq_rem_reg  <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
                    sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
                    sq_cnt_reg  <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 6'(ROOT_W - 1)) begin
                        if (job_reg == J_SEG) begin
                            state_reg <= S_APP_WR;
                        end else begin
                            len_reg    <= {sq_root_reg[ROOT_W-2:0], sq_ge};
                            dv_num_reg <= {dot_mag_reg, 16'd0};
                            dv_rem_reg <= '0;
                            dv_q_reg   <= '0;
                            dv_ovf_reg <= 1'b0;
                            dv_cnt_reg <= '0;
                            dv_sel_reg <= 1'b0;
                            state_reg  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    dv_num_reg <= dv_num_reg << 1;
                    dv_rem_reg <= dv_ge ? dv_rem_sh - dv_den : dv_rem_sh;
                    dv_q_reg   <= {dv_q_reg[QUO_W-2:0], dv_ge};
                    dv_ovf_reg <= dv_ovf_reg | dv_q_reg[QUO_W-1];
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                    if (dv_cnt_reg == 7'(NUM_W - 1)) begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    if (!dv_sel_reg) begin
                        res_s_reg  <= s_sum[QUO_W] ? '1 : s_sum[QUO_W-1:0];
                        dv_num_reg <= {c_abs[65:0], 16'd0};
                        dv_rem_reg <= '0;
                        dv_q_reg   <= '0;
                        dv_ovf_reg <= 1'b0;
                        dv_cnt_reg <= '0;
                        dv_sel_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end else begin
                        res_d_reg  <= d_neg_reg ? 32'd0 - dm_sat : dm_sat;
                        res_st_reg <= c2f_pkg::ST_OK;
                        state_reg  <= S_OUT;
                    end
                end
                S_APP_WAIT: state_reg <= S_APP_GET;
                S_APP_GET: begin
                    ax_reg    <= c2f_pkg::sub33(wx_reg, rdx_reg);
                    ay_reg    <= c2f_pkg::sub33(wy_reg, rdy_reg);
                    pcum_reg  <= rdc_reg;
                    job_reg   <= J_SEG;
                    state_reg <= S_MP1;
                end
                S_APP_WR: begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_idx_reg, res_d_reg, res_s_reg};
                        m_tuser_reg  <= res_st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `C2F_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_WAYPOINTS), "waypoint count beyond table depth")
    `C2F_ASSERT_NEXT(a_empty_query, aclk, aresetn, s_acc && s_tuser == c2f_pkg::MODE_QUERY && cnt_reg == '0, state_reg == S_OUT, "empty table query did not go to output")
    `C2F_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid_reg && m_tuser_reg != c2f_pkg::ST_OK, m_tdata_reg[63:0] == 64'd0, "error result carries nonzero s or d")

endmodule
